// File: hw/rtl/keypad_code_lock_macros.svh
// assertion macros for the keypad code lock checker
`ifndef KEYPAD_CODE_LOCK_MACROS_SVH
`define KEYPAD_CODE_LOCK_MACROS_SVH

// clocked property, switched off while reset is held
`define KCL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked property that also holds during reset
`define KCL_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hw/rtl/kcl_pkg.sv
// shared types, constants and functions of the keypad code lock
`default_nettype none

package kcl_pkg;

    localparam int CODE_DIGITS_DEF = 8;
    localparam int PLACES          = 8;

    typedef logic [PLACES-1:0][4:0] entry_t;
    typedef logic [PLACES-1:0][3:0] code_t;

    // bit 4 set marks a blank place
    localparam logic [4:0] BLANK          = 5'd16;
    localparam logic [7:0] SEG_UNDERSCORE = 8'h08;
    localparam logic [7:0] SEG_DARK       = 8'h00;

    localparam entry_t ENTRY_CLEAR  = {PLACES{BLANK}};
    localparam code_t  STORED_RESET = {4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1};

    typedef enum logic [1:0] {
        CMD_KEY   = 2'd0,
        CMD_CHECK = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_SET   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_NONE       = 3'd0,
        ST_INCOMPLETE = 3'd1,
        ST_CORRECT    = 3'd2,
        ST_WRONG      = 3'd3,
        ST_AGAIN      = 3'd4,
        ST_SAVED      = 3'd5,
        ST_NOT_SAME   = 3'd6
    } status_t;

    // state after one item, as seen by the readout and the result register
    typedef struct packed {
        status_t    status;
        entry_t     entry;
        logic [3:0] pos;
        logic       set_mode;
    } view_t;

    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = SEG_DARK;
        endcase
        return s;
    endfunction

    // compares the first cd places of the entry with a code
    function automatic logic code_match(input entry_t e, input code_t c, input logic [3:0] cd);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < PLACES; k++) begin
            if (4'(k) < cd && e[k] != {1'b0, c[k]}) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/kcl_core.sv
// lock state: entry buffer, stored code, set mode sequencing and status
`default_nettype none

module kcl_core #(
    parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step,
    input  wire kcl_pkg::cmd_t cmd,
    input  wire logic [3:0]    key,
    output kcl_pkg::view_t     view
);

    localparam logic [3:0] CD = 4'(CODE_DIGITS);

    kcl_pkg::entry_t  entry_reg, entry_next;
    logic [3:0]       pos_reg, pos_next;
    kcl_pkg::code_t   stored_reg, stored_next;
    kcl_pkg::code_t   first_reg, first_next;
    logic             fe_reg, fe_next;
    logic             setm_reg, setm_next;
    kcl_pkg::status_t status;

    always_comb begin
        entry_next  = entry_reg;
        pos_next    = pos_reg;
        stored_next = stored_reg;
        first_next  = first_reg;
        fe_next     = fe_reg;
        setm_next   = setm_reg;
        status      = kcl_pkg::ST_NONE;

        case (cmd)
            kcl_pkg::CMD_KEY: begin
                if (key <= 4'd9 && pos_reg < CD) begin
                    entry_next[pos_reg[2:0]] = {1'b0, key};
                    pos_next = pos_reg + 4'd1;
                end
            end
            kcl_pkg::CMD_CHECK: begin
                if (pos_reg < CD) begin
                    status = kcl_pkg::ST_INCOMPLETE;
                end else begin
                    status = kcl_pkg::code_match(entry_reg, stored_reg, CD) ?
                             kcl_pkg::ST_CORRECT : kcl_pkg::ST_WRONG;
                    entry_next = kcl_pkg::ENTRY_CLEAR;
                    pos_next   = 4'd0;
                end
            end
            kcl_pkg::CMD_CLEAR: begin
                entry_next = kcl_pkg::ENTRY_CLEAR;
                pos_next   = 4'd0;
            end
            default: begin
                setm_next = 1'b1;
            end
        endcase

        // full entry in set mode is taken at once
        if (setm_next && pos_next >= CD) begin
            if (!fe_reg) begin
                for (int k = 0; k < kcl_pkg::PLACES; k++) begin
                    first_next[k] = entry_next[k][3:0];
                end
                fe_next = 1'b1;
                status  = kcl_pkg::ST_AGAIN;
            end else begin
                if (kcl_pkg::code_match(entry_next, first_reg, CD)) begin
                    stored_next = first_reg;
                    setm_next   = 1'b0;
                    status      = kcl_pkg::ST_SAVED;
                end else begin
                    status = kcl_pkg::ST_NOT_SAME;
                end
                fe_next = 1'b0;
            end
            entry_next = kcl_pkg::ENTRY_CLEAR;
            pos_next   = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg  <= kcl_pkg::ENTRY_CLEAR;
            pos_reg    <= 4'd0;
            stored_reg <= kcl_pkg::STORED_RESET;
            fe_reg     <= 1'b0;
            setm_reg   <= 1'b0;
        end else if (step) begin
            entry_reg  <= entry_next;
            pos_reg    <= pos_next;
            stored_reg <= stored_next;
            fe_reg     <= fe_next;
            setm_reg   <= setm_next;
        end
    end

    // first code is only read after it has been written
    always_ff @(posedge aclk) begin
        if (step) begin
            first_reg <= first_next;
        end
    end

    assign view.status   = status;
    assign view.entry    = entry_next;
    assign view.pos      = pos_next;
    assign view.set_mode = setm_next;

endmodule

`default_nettype wire

// File: hw/rtl/kcl_disp.sv
// seven-segment readout of the entry buffer
`default_nettype none

module kcl_disp #(
    parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
    input  wire kcl_pkg::view_t view,
    input  wire logic           phase,
    output logic [63:0]         segments
);

    always_comb begin
        for (int k = 0; k < kcl_pkg::PLACES; k++) begin
            if (k >= CODE_DIGITS) begin
                segments[8*k +: 8] = kcl_pkg::SEG_DARK;
            end else if (!view.entry[k][4]) begin
                segments[8*k +: 8] = kcl_pkg::seg_of(view.entry[k][3:0]);
            end else if (4'(k) == view.pos) begin
                segments[8*k +: 8] = phase ? kcl_pkg::SEG_UNDERSCORE : kcl_pkg::SEG_DARK;
            end else begin
                segments[8*k +: 8] = kcl_pkg::SEG_UNDERSCORE;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/keypad_code_lock.sv
// keypad code lock top level: input register, lock logic, readout, result register
//
// usage
//   s_ channel: one item per key event (command, key_value, blink_phase)
//   m_ channel: exactly one result item per input item, in order, with the
//     status and the state after the item (readout, digit count, set mode)
//   an item passes the input register, then the result register; m_valid rises
//     once the item has moved into the result register
//   throughput: one item per cycle while m_ready stays high; the input register is
//     emptied into the result register whenever that one is free or being taken
//   the lock state advances as an item moves into the result register, so a
//     stalled receiver holds the pipe: up to two items sit in the block and
//     s_ready falls only when both registers are full and m_ready is low
//   reset (aresetn low, synchronous): both channels empty, entry cleared,
//     set mode off, stored code back to 1 2 3 4 5 6 7 8
//   CODE_DIGITS (1 to 8) sets how many places make a full entry
`default_nettype none

module keypad_code_lock #(
    parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [3:0]  s_key_value,
    input  wire logic        s_blink_phase,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [63:0]      m_segments,
    output logic [3:0]       m_digits_entered,
    output logic             m_in_set_mode
);

    // input register
    logic          in_vld_reg, in_vld_next;
    kcl_pkg::cmd_t cmd_reg;
    logic [3:0]    key_reg;
    logic          phase_reg;

    // result register
    logic          out_vld_reg, out_vld_next;
    logic [2:0]    status_reg;
    logic [63:0]   segments_reg;
    logic [3:0]    digits_reg;
    logic          setm_reg;

    logic           s_fire;
    logic           adv;
    kcl_pkg::view_t view;
    logic [63:0]    segments;

    // item moves from the input register into the result register
    assign adv     = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || adv;
    assign s_fire  = s_valid && s_ready;

    assign in_vld_next  = s_fire || (in_vld_reg && !adv);
    assign out_vld_next = adv || (out_vld_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg   <= kcl_pkg::cmd_t'(s_command);
            key_reg   <= s_key_value;
            phase_reg <= s_blink_phase;
        end
    end

    kcl_core #(
        .CODE_DIGITS(CODE_DIGITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (adv),
        .cmd     (cmd_reg),
        .key     (key_reg),
        .view    (view)
    );

    kcl_disp #(
        .CODE_DIGITS(CODE_DIGITS)
    ) u_disp (
        .view     (view),
        .phase    (phase_reg),
        .segments (segments)
    );

    // result payload, loaded only when an item advances
    always_ff @(posedge aclk) begin
        if (adv) begin
            status_reg   <= view.status;
            segments_reg <= segments;
            digits_reg   <= view.pos;
            setm_reg     <= view.set_mode;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_status         = status_reg;
    assign m_segments       = segments_reg;
    assign m_digits_entered = digits_reg;
    assign m_in_set_mode    = setm_reg;

endmodule

`default_nettype wire

// File: hw/rtl/kcl_checker.sv
// port-level checker of the keypad code lock and its bind
`default_nettype none

`include "keypad_code_lock_macros.svh"

module kcl_checker #(
    parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic [63:0] m_segments,
    input wire logic [3:0]  m_digits_entered,
    input wire logic        m_in_set_mode
);

    `KCL_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result after reset")

    `KCL_ASSERT(a_stall_hold, m_valid && !m_ready |=> m_valid && $stable(m_segments), "stalled result changed")

    `KCL_ASSERT(a_count_range, m_valid |-> m_digits_entered <= 4'(CODE_DIGITS), "digit count out of range")

    `KCL_ASSERT(a_status_code, m_valid |-> m_status <= kcl_pkg::ST_NOT_SAME, "bad status code")

    `KCL_ASSERT(a_saved_state, m_valid && m_status == kcl_pkg::ST_SAVED |-> !m_in_set_mode && m_digits_entered == 4'd0, "saved code left state behind")

endmodule

bind keypad_code_lock kcl_checker #(.CODE_DIGITS(CODE_DIGITS)) u_kcl_checker (.*);

`default_nettype wire

// File: test/tb.sv
// self-checking testbench for the keypad code lock: directed table, random key sessions, checker
`timescale 1ns / 1ps

module tb;
    import kcl_pkg::*;

    // one result item as the lock should report it
    typedef struct packed {
        status_t     status;
        logic [63:0] segs;
        logic [3:0]  digits;
        logic        set_mode;
    } lock_result_t;

    // one row of the directed table; typed rows carry their own expected result
    typedef struct packed {
        cmd_t         cmd;
        logic [3:0]   key;
        logic         phase;
        bit           typed;
        lock_result_t want;
    } key_row_t;

    localparam logic [3:0]  FULL_COUNT = 4'd8;
    localparam logic [63:0] ALL_UNDER  = {8{SEG_UNDERSCORE}};
    // place 0 is the current blank place, dark with blink phase 0
    localparam logic [63:0] FIRST_DARK = {{7{SEG_UNDERSCORE}}, SEG_DARK};
    localparam int          HOLD_CYCLES = 60;
    localparam int          RAND_PER_PHASE = 170;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [3:0]  s_key_value;
    logic        s_blink_phase;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [63:0] m_segments;
    logic [3:0]  m_digits_entered;
    logic        m_in_set_mode;

    keypad_code_lock u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_key_value      (s_key_value),
        .s_blink_phase    (s_blink_phase),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_segments       (m_segments),
        .m_digits_entered (m_digits_entered),
        .m_in_set_mode    (m_in_set_mode)
    );

    // clock, 10 ns period
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // predictor copy of the lock state
    entry_t     lk_entry;
    logic [3:0] lk_pos;
    code_t      lk_stored;
    code_t      lk_first;
    logic       lk_first_taken;
    logic       lk_set_mode;

    // results still owed by the block, oldest first
    lock_result_t lock_results_q[$];

    // what the sender currently offers beyond the payload itself
    bit           offered_typed;
    lock_result_t offered_exp;

    int snd_idle_pct;
    int rcv_idle_pct;
    bit hold_req;
    int hold_left;

    int err_cnt;
    int items_in;
    int results_seen;
    int rand_items;
    int dir_items;
    int status_cnt[0:7];

    key_row_t key_table[$];

    // seven-segment code of one decimal digit
    function automatic logic [7:0] digit_pattern(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'h3f;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5b;
            4'd3:    p = 8'h4f;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6d;
            4'd6:    p = 8'h7d;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7f;
            default: p = 8'h6f;
        endcase
        return p;
    endfunction

    // advance the lock state by one item and return the result it causes
    function automatic lock_result_t predict_lock(input cmd_t cmd, input logic [3:0] key,
                                                  input logic phase);
        lock_result_t r;
        logic         hit;
        r = '{status: ST_NONE, segs: '0, digits: '0, set_mode: 1'b0};
        case (cmd)
            CMD_KEY: begin
                // keys above nine and keys into a full entry do nothing
                if (key <= 4'd9 && lk_pos < FULL_COUNT) begin
                    lk_entry[lk_pos[2:0]] = {1'b0, key};
                    lk_pos = lk_pos + 4'd1;
                end
            end
            CMD_CHECK: begin
                if (lk_pos < FULL_COUNT) begin
                    r.status = ST_INCOMPLETE;
                end else begin
                    hit = 1'b1;
                    for (int k = 0; k < 8; k++) begin
                        if (lk_entry[k] != {1'b0, lk_stored[k]}) hit = 1'b0;
                    end
                    r.status = hit ? ST_CORRECT : ST_WRONG;
                    lk_entry = ENTRY_CLEAR;
                    lk_pos   = '0;
                end
            end
            CMD_CLEAR: begin
                lk_entry = ENTRY_CLEAR;
                lk_pos   = '0;
            end
            default: begin
                lk_set_mode = 1'b1;
            end
        endcase

        // a full entry never waits while setting: first code, then confirmation
        if (lk_set_mode && lk_pos >= FULL_COUNT) begin
            if (!lk_first_taken) begin
                for (int k = 0; k < 8; k++) lk_first[k] = lk_entry[k][3:0];
                lk_first_taken = 1'b1;
                r.status = ST_AGAIN;
            end else begin
                hit = 1'b1;
                for (int k = 0; k < 8; k++) begin
                    if (lk_entry[k] != {1'b0, lk_first[k]}) hit = 1'b0;
                end
                if (hit) begin
                    lk_stored   = lk_first;
                    lk_set_mode = 1'b0;
                    r.status    = ST_SAVED;
                end else begin
                    r.status = ST_NOT_SAME;
                end
                lk_first_taken = 1'b0;
            end
            lk_entry = ENTRY_CLEAR;
            lk_pos   = '0;
        end

        // readout: digits, blinking underscore at the current place, else underscore
        for (int k = 0; k < 8; k++) begin
            if (!lk_entry[k][4]) begin
                r.segs[8*k +: 8] = digit_pattern(lk_entry[k][3:0]);
            end else if (4'(k) == lk_pos) begin
                r.segs[8*k +: 8] = phase ? SEG_UNDERSCORE : SEG_DARK;
            end else begin
                r.segs[8*k +: 8] = SEG_UNDERSCORE;
            end
        end
        r.digits   = lk_pos;
        r.set_mode = lk_set_mode;
        return r;
    endfunction

    // one line per mismatch, printing capped so a broken block cannot flood the log
    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (err_cnt < 40) begin
            $display("MISMATCH at %0t: %s got %h want %h", $realtime, what, got, want);
        end
        err_cnt++;
    endtask

    // monitor: predict on every accepted item, check every accepted result
    always @(posedge aclk) begin
        lock_result_t exp_r;
        lock_result_t pred_r;
        if (!aresetn) begin
            lk_entry       = ENTRY_CLEAR;
            lk_pos         = '0;
            lk_stored      = STORED_RESET;
            lk_first       = '0;
            lk_first_taken = 1'b0;
            lk_set_mode    = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pred_r = predict_lock(cmd_t'(s_command), s_key_value, s_blink_phase);
                exp_r  = offered_typed ? offered_exp : pred_r;
                lock_results_q.push_back(exp_r);
                status_cnt[int'(exp_r.status)]++;
                items_in++;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (lock_results_q.size() == 0) begin
                    note_mismatch("result with nothing expected", m_segments, '0);
                end else begin
                    exp_r = lock_results_q.pop_front();
                    if (m_status != exp_r.status)
                        note_mismatch("status", 64'(m_status), 64'(exp_r.status));
                    if (m_segments != exp_r.segs)
                        note_mismatch("segments", m_segments, exp_r.segs);
                    if (m_digits_entered != exp_r.digits)
                        note_mismatch("digits_entered", 64'(m_digits_entered),
                                      64'(exp_r.digits));
                    if (m_in_set_mode != exp_r.set_mode)
                        note_mismatch("in_set_mode", 64'(m_in_set_mode), 64'(exp_r.set_mode));
                end
            end
        end
    end

    // receiver: random stalls, or one long hold-off counted here when asked
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // offer one item and wait for it to be taken; inputs move on the falling edge
    task automatic send_item(input cmd_t cmd, input logic [3:0] key, input logic phase);
        @(negedge aclk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_key_value   <= key;
        s_blink_phase <= phase;
        do @(posedge aclk); while (!s_ready);
        // keys above nine do not count toward the random budget
        if (!(cmd == CMD_KEY && key > 4'd9)) rand_items++;
    endtask

    // key in a whole eight-digit code
    task automatic send_code(input code_t c);
        for (int k = 0; k < 8; k++) send_item(CMD_KEY, c[k], 1'($urandom_range(1)));
    endtask

    // change one place of a code to a different digit
    function automatic code_t bend_code(input code_t c);
        int p;
        code_t r;
        r = c;
        p = $urandom_range(7);
        r[p] = 4'((int'(c[p]) + 1 + $urandom_range(8)) % 10);
        return r;
    endfunction

    function automatic code_t random_code();
        code_t r;
        for (int k = 0; k < 8; k++) r[k] = 4'($urandom_range(9));
        return r;
    endfunction

    // one short user session: mostly well-formed, some noise
    task automatic run_session();
        int    kind;
        int    n;
        code_t a;
        code_t b;
        kind = $urandom_range(99);
        if (kind < 30) begin
            // unlock attempt, usually with the stored code
            if ($urandom_range(1) == 1) send_item(CMD_CLEAR, 4'($urandom), 1'($urandom));
            a = ($urandom_range(3) != 0) ? lk_stored : random_code();
            if ($urandom_range(4) == 0) a = bend_code(a);
            send_code(a);
            // sometimes a stray key on the full entry
            if ($urandom_range(9) == 0) send_item(CMD_KEY, 4'($urandom), 1'($urandom));
            send_item(CMD_CHECK, 4'($urandom), 1'($urandom));
        end else if (kind < 55) begin
            // set a new code, confirmation usually right
            send_item(CMD_SET, 4'($urandom), 1'($urandom));
            if ($urandom_range(5) == 0) send_item(CMD_SET, 4'($urandom), 1'($urandom));
            a = random_code();
            send_code(a);
            if ($urandom_range(7) == 0) send_item(CMD_CHECK, 4'($urandom), 1'($urandom));
            b = ($urandom_range(3) == 0) ? bend_code(a) : a;
            send_code(b);
            if ($urandom_range(1) == 1) begin
                send_code(lk_stored);
                send_item(CMD_CHECK, 4'($urandom), 1'($urandom));
            end
        end else if (kind < 75) begin
            // partial entry, then check, clear or set mode
            n = $urandom_range(7);
            for (int k = 0; k < n; k++) send_item(CMD_KEY, 4'($urandom_range(9)), 1'($urandom));
            send_item(cmd_t'(1 + $urandom_range(2)), 4'($urandom), 1'($urandom));
        end else begin
            // noise: any command, any key
            n = 1 + $urandom_range(5);
            for (int k = 0; k < n; k++) send_item(cmd_t'($urandom_range(3)), 4'($urandom),
                                                  1'($urandom));
        end
    endtask

    // stop offering, then wait for every owed result, with a bound
    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (lock_results_q.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    function automatic key_row_t pr(input cmd_t cmd, input logic [3:0] key, input logic ph);
        key_row_t r;
        r = '0;
        r.cmd = cmd;
        r.key = key;
        r.phase = ph;
        return r;
    endfunction

    function automatic key_row_t tr(input cmd_t cmd, input logic [3:0] key, input logic ph,
                                    input status_t st, input logic [63:0] segs,
                                    input logic [3:0] dig, input logic sm);
        key_row_t r;
        r = pr(cmd, key, ph);
        r.typed = 1'b1;
        r.want  = '{status: st, segs: segs, digits: dig, set_mode: sm};
        return r;
    endfunction

    // guard against a hung handshake
    initial begin
        #2_000_000;
        $display("keypad_code_lock test failed");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_command     = CMD_KEY;
        s_key_value   = '0;
        s_blink_phase = 1'b0;
        m_ready       = 1'b0;
        offered_typed = 1'b0;
        offered_exp   = '0;
        hold_req      = 1'b0;
        hold_left     = 0;
        snd_idle_pct  = 15;
        rcv_idle_pct  = 45;
        err_cnt       = 0;
        items_in      = 0;
        results_seen  = 0;
        rand_items    = 0;
        for (int k = 0; k < 8; k++) status_cnt[k] = 0;

        // directed table: empty check, ignored key, clear, unlock, set mode paths
        key_table.push_back(tr(CMD_CHECK, 4'd0, 1'b1, ST_INCOMPLETE, ALL_UNDER, 4'd0, 1'b0));
        key_table.push_back(tr(CMD_KEY, 4'd15, 1'b0, ST_NONE, FIRST_DARK, 4'd0, 1'b0));
        key_table.push_back(pr(CMD_KEY, 4'd0, 1'b1));
        key_table.push_back(tr(CMD_CLEAR, 4'd9, 1'b0, ST_NONE, FIRST_DARK, 4'd0, 1'b0));
        // the code after reset, then a key on the full entry
        for (int k = 1; k <= 8; k++) key_table.push_back(pr(CMD_KEY, 4'(k), 1'(k)));
        key_table.push_back(pr(CMD_KEY, 4'd9, 1'b1));
        key_table.push_back(tr(CMD_CHECK, 4'd0, 1'b1, ST_CORRECT, ALL_UNDER, 4'd0, 1'b0));
        // a full entry waiting when set mode comes is taken at once
        for (int k = 0; k < 8; k++) key_table.push_back(pr(CMD_KEY, (k % 2) ? 4'd0 : 4'd9, 1'b0));
        key_table.push_back(tr(CMD_SET, 4'd0, 1'b1, ST_AGAIN, ALL_UNDER, 4'd0, 1'b1));
        // set mode again keeps the first code, check there is always incomplete
        key_table.push_back(pr(CMD_SET, 4'd15, 1'b1));
        key_table.push_back(tr(CMD_CHECK, 4'd0, 1'b0, ST_INCOMPLETE, FIRST_DARK, 4'd0, 1'b1));
        for (int k = 0; k < 7; k++) key_table.push_back(pr(CMD_KEY, (k % 2) ? 4'd0 : 4'd9, 1'b1));
        key_table.push_back(tr(CMD_KEY, 4'd0, 1'b1, ST_SAVED, ALL_UNDER, 4'd0, 1'b0));
        // the new code with its last place wrong
        for (int k = 0; k < 7; k++) key_table.push_back(pr(CMD_KEY, (k % 2) ? 4'd0 : 4'd9, 1'b0));
        key_table.push_back(pr(CMD_KEY, 4'd1, 1'b0));
        key_table.push_back(tr(CMD_CHECK, 4'd3, 1'b1, ST_WRONG, ALL_UNDER, 4'd0, 1'b0));
        dir_items = key_table.size();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // row expectations change after the monitor has seen the accepting edge
        foreach (key_table[i]) begin
            offered_typed <= key_table[i].typed;
            offered_exp   <= key_table[i].want;
            send_item(key_table[i].cmd, key_table[i].key, key_table[i].phase);
        end
        offered_typed <= 1'b0;
        rand_items    = 0;

        // phase one: sender idles a little, receiver a lot, with one long hold-off
        hold_req = 1'b1;
        while (rand_items < RAND_PER_PHASE) run_session();

        // sender pauses until everything has come out
        drain_results();
        snd_idle_pct = 45;
        rcv_idle_pct = 15;
        while (rand_items < 2 * RAND_PER_PHASE) run_session();

        // phase three: full rate on both sides
        drain_results();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        while (rand_items < 3 * RAND_PER_PHASE) run_session();

        @(negedge aclk);
        s_valid <= 1'b0;
        drain_results();
        repeat (20) @(posedge aclk);
        if (lock_results_q.size() != 0) begin
            note_mismatch("results never delivered", 64'(lock_results_q.size()), '0);
        end

        $display("ran %0d items (%0d from the table), checked %0d results, %0d mismatches",
                 items_in, dir_items, results_seen, err_cnt);
        $display("outcomes: correct %0d, wrong %0d, again %0d, saved %0d, not same %0d",
                 status_cnt[ST_CORRECT], status_cnt[ST_WRONG], status_cnt[ST_AGAIN],
                 status_cnt[ST_SAVED], status_cnt[ST_NOT_SAME]);
        if (err_cnt == 0) begin
            $display("keypad_code_lock test passed");
        end else begin
            $display("keypad_code_lock test failed");
        end
        $finish;
    end

endmodule
